### rtl/hrlp_pkg.sv
// Package for the HTTP request line parser: parse phases, byte codes and
// the method-name and protocol-literal matchers. No dependencies.
package hrlp_pkg;

    localparam int MAX_LINE_DEF = 4096;
    localparam int CNT_W        = 12;
    localparam int HIST_W       = 56;
    localparam int LIT_LEN      = 5;
    localparam int S_DATA_W     = 8;
    localparam int M_DATA_W     = 72;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_METHOD = 4'd1,
        PH_SP1    = 4'd2,
        PH_TARGET = 4'd3,
        PH_SP2    = 4'd4,
        PH_LIT    = 4'd5,
        PH_MAJ0   = 4'd6,
        PH_MAJ    = 4'd7,
        PH_MIN    = 4'd8,
        PH_DONE   = 4'd9,
        PH_DRAIN  = 4'd10
    } phase_t;

    function automatic logic verb_hit(input logic [HIST_W-1:0] h);
        logic hit;
        hit = (h[23:0] == "GET")     || (h[31:0] == "HEAD")    ||
              (h[31:0] == "POST")    || (h[23:0] == "PUT")     ||
              (h[47:0] == "DELETE")  || (h[55:0] == "CONNECT") ||
              (h[55:0] == "OPTIONS") || (h[39:0] == "TRACE");
        return hit;
    endfunction

    function automatic logic [7:0] lit_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

### rtl/http_request_line_parser_top.sv
// Top level of the HTTP request line parser: byte-per-word parse state and
// one registered result word per line. Depends on hrlp_pkg.
//
// Usage: s_ carries one request byte per word in s_tdata, with s_tuser high
// on the first byte of a buffer, which restarts the parse. m_ carries one
// result word at the LF of the first CR LF pair of a started line; other
// bytes give no result. A zero byte or a new start drops the line silently.
// Throughput: one byte per cycle while s_tready is high; the parse state
// updates at the byte's accepting edge, and a CR that is not followed by
// LF is folded into the next byte's update, so no cycle is lost.
// Latency: the result word is valid the cycle after the LF is accepted.
// Stall: while a result is held and m_tready is low, s_tready drops; in
// all other cycles s_tready stays high, also while a result is taken.
// Reset (aresetn low at a clock edge): the parser goes idle, discarding bytes
// until the next start, and the result register empties.
module http_request_line_parser_top #(
    parameter int MAX_LINE = hrlp_pkg::MAX_LINE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hrlp_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] byte_in
    input  logic                          s_tuser,   // [0] start_req
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] ok, [1] overlong, [13:2] method_length, [25:14] target_offset,
    // [37:26] target_length, [53:38] version, [65:54] line_length, rest zero
    output logic [hrlp_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int POS_W = $clog2(MAX_LINE + 5);
    localparam logic [POS_W-1:0] LINE_CAP = POS_W'(MAX_LINE + 2);
    localparam logic [POS_W-1:0] LINE_MAX = POS_W'(MAX_LINE);
    localparam int CW = hrlp_pkg::CNT_W;

    typedef struct packed {
        hrlp_pkg::phase_t              phase;
        logic [POS_W-1:0]              position;
        logic [POS_W-1:0]              method_len;
        logic [hrlp_pkg::HIST_W-1:0]   history;
        logic                          found;
        logic [POS_W-1:0]              tgt_start;
        logic [POS_W-1:0]              tgt_len;
        logic [2:0]                    lit_idx;
        logic [7:0]                    major;
        logic [7:0]                    minor;
        logic                          err;
    } line_t;

    function automatic logic [CW-1:0] sat12(input logic [POS_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'd4095) ? {CW{1'b1}} : wide[CW-1:0];
    endfunction

    function automatic line_t feed(input line_t s, input logic [7:0] c);
        line_t      r;
        logic       digit;
        logic [7:0] dval;
        logic [2:0] idx;
        r     = s;
        digit = (c >= hrlp_pkg::CH_ZERO) && (c <= hrlp_pkg::CH_NINE);
        dval  = c - hrlp_pkg::CH_ZERO;
        idx   = (s.phase == hrlp_pkg::PH_SP2) ? 3'd0 : s.lit_idx;
        if (s.phase == hrlp_pkg::PH_IDLE) begin
            return r;
        end
        if (c == hrlp_pkg::CH_NUL) begin
            r.phase = hrlp_pkg::PH_IDLE;
            return r;
        end
        unique case (s.phase) inside
            hrlp_pkg::PH_METHOD: begin
                if (c == hrlp_pkg::CH_SPACE) begin
                    r.method_len = s.position;
                    if (s.position == '0 || !s.found) begin
                        r.err   = 1'b1;
                        r.phase = hrlp_pkg::PH_DRAIN;
                    end else begin
                        r.phase = hrlp_pkg::PH_SP1;
                    end
                end else begin
                    r.history = {s.history[hrlp_pkg::HIST_W-9:0], c};
                    if (hrlp_pkg::verb_hit(r.history)) begin
                        r.found = 1'b1;
                    end
                end
            end
            hrlp_pkg::PH_SP1: begin
                if (c != hrlp_pkg::CH_SPACE) begin
                    r.tgt_start = s.position;
                    r.phase     = hrlp_pkg::PH_TARGET;
                end
            end
            hrlp_pkg::PH_TARGET: begin
                if (c == hrlp_pkg::CH_SPACE) begin
                    r.tgt_len = s.position - s.tgt_start;
                    r.phase   = hrlp_pkg::PH_SP2;
                end
            end
            hrlp_pkg::PH_SP2, hrlp_pkg::PH_LIT: begin
                if (s.phase == hrlp_pkg::PH_SP2 && c == hrlp_pkg::CH_SPACE) begin
                    r.phase = hrlp_pkg::PH_SP2;
                end else if (32'(idx) >= hrlp_pkg::LIT_LEN
                             || c != hrlp_pkg::lit_char(idx)) begin
                    r.lit_idx = idx;
                    r.err     = 1'b1;
                    r.phase   = hrlp_pkg::PH_DRAIN;
                end else begin
                    r.lit_idx = idx + 3'd1;
                    r.phase   = (32'(idx) == hrlp_pkg::LIT_LEN - 1) ?
                                hrlp_pkg::PH_MAJ0 : hrlp_pkg::PH_LIT;
                end
            end
            hrlp_pkg::PH_MAJ0: begin
                if (digit) begin
                    r.major = dval;
                    r.phase = hrlp_pkg::PH_MAJ;
                end else begin
                    r.err   = 1'b1;
                    r.phase = hrlp_pkg::PH_DRAIN;
                end
            end
            hrlp_pkg::PH_MAJ: begin
                if (digit) begin
                    r.major = {s.major[4:0], 3'b000} + {s.major[6:0], 1'b0} + dval;
                end else if (c == hrlp_pkg::CH_DOT) begin
                    r.phase = hrlp_pkg::PH_MIN;
                end else begin
                    r.phase = hrlp_pkg::PH_DONE;
                end
            end
            hrlp_pkg::PH_MIN: begin
                if (digit) begin
                    r.minor = {s.minor[4:0], 3'b000} + {s.minor[6:0], 1'b0} + dval;
                end else begin
                    r.phase = hrlp_pkg::PH_DONE;
                end
            end
            default: begin
                r.phase = s.phase;
            end
        endcase
        if (s.position < LINE_CAP) begin
            r.position = s.position + POS_W'(1);
        end
        return r;
    endfunction

    line_t                        line_reg, line_next, line_start, line_fed;
    logic                         pending_reg, pending_next, pending_fed;
    logic                         fire;
    logic                         s_accept;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [hrlp_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next, result;
    logic [7:0]                   byte_in;
    logic [POS_W-1:0]             len_raw, len;
    logic                         over, good;

    assign byte_in  = s_tdata[7:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        line_start = line_reg;
        if (s_tuser) begin
            line_start       = '0;
            line_start.phase = hrlp_pkg::PH_METHOD;
        end
    end

    always_comb begin
        line_fed    = line_start;
        pending_fed = s_tuser ? 1'b0 : pending_reg;
        fire        = 1'b0;
        if (line_start.phase != hrlp_pkg::PH_IDLE) begin
            if (pending_fed) begin
                pending_fed = 1'b0;
                if (byte_in == hrlp_pkg::CH_LF) begin
                    fire           = 1'b1;
                    line_fed.phase = hrlp_pkg::PH_IDLE;
                end else begin
                    line_fed = feed(line_fed, hrlp_pkg::CH_CR);
                end
            end
            if (!fire) begin
                if (byte_in == hrlp_pkg::CH_CR) begin
                    pending_fed = 1'b1;
                end else begin
                    line_fed = feed(line_fed, byte_in);
                end
            end
        end
        line_next    = s_accept ? line_fed : line_reg;
        pending_next = s_accept ? pending_fed : pending_reg;
    end

    always_comb begin
        len_raw = line_start.position + POS_W'(2);
        len     = (len_raw > LINE_CAP) ? LINE_CAP : len_raw;
        over    = len > LINE_MAX;
        good    = !line_start.err && !over &&
                  (line_start.phase == hrlp_pkg::PH_MAJ ||
                   line_start.phase == hrlp_pkg::PH_MIN ||
                   line_start.phase == hrlp_pkg::PH_DONE);
        result  = '0;
        result[0]     = good;
        result[1]     = over;
        result[65:54] = sat12(len);
        if (good) begin
            result[13:2]  = sat12(line_start.method_len);
            result[25:14] = sat12(line_start.tgt_start);
            result[37:26] = sat12(line_start.tgt_len);
            result[53:38] = {line_start.major, line_start.minor};
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (s_accept && fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg       <= '0;
            pending_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            line_reg       <= line_next;
            pending_reg    <= pending_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule
